### rtl/hfd_pkg.sv
package hfd_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = PROD_W - FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_YIELD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLASTIC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FGAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DT  = 3'd4;

    localparam logic [CFG_W-1:0]  ONE_Q16_CFG = 31'h0001_0000;
    localparam logic [DATA_W-1:0] ONE_Q16     = 32'h0001_0000;

    typedef logic signed [DATA_W-1:0] q16_t;

    // sign-magnitude to saturated two's complement
    function automatic logic [DATA_W-1:0] sat_q16(input logic neg, input logic [MAG_W-1:0] mag);
        logic [DATA_W-1:0] r;
        if (!neg)
        begin
            r = (mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
        end
        else
        begin
            r = (mag > MAG_W'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - mag[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

### rtl/hfd_if.sv
interface hfd_in_if
    import hfd_pkg::*;
();
    logic  valid;
    logic  ready;
    q16_t  displacement;

    modport source (output valid, output displacement, input ready);
    modport sink   (input valid, input displacement, output ready);
endinterface

interface hfd_out_if
    import hfd_pkg::*;
();
    logic  valid;
    logic  ready;
    q16_t  drag_force;
    q16_t  velocity;

    modport source (output valid, output drag_force, output velocity, input ready);
    modport sink   (input valid, input drag_force, input velocity, output ready);
endinterface

### rtl/hfd_mul.sv
module hfd_mul
    import hfd_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  p
);

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

### rtl/hysteretic_friction_damper_step.sv
// channel | dir | payload                      | handshake
// in_ch   | in  | displacement (s32 Q16.16)    | valid/ready
// out_ch  | out | drag_force, velocity         | valid/ready
// cfg     | in  | cfg_index, cfg_data (31 b)   | cfg_we, no stall
//
// Each word: accept, then seven sequencer steps that feed
// four dependent products through the single registered 33x32 multiplier.
// in_ch.ready is high only while the sequencer is idle.
// A finished word sits in the output register; the next input is taken
// meanwhile, and the last step waits only if that register is still full.
// rst_n clears state, hysteretic value, previous displacement and output valid.
module hysteretic_friction_damper_step
    import hfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hfd_in_if.sink               in_ch,
    hfd_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        IDLE, S_VEL, S_GAIN, S_HQ, S_STEP, S_UPD, S_FORCE, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] yield_reg, plastic_reg, span_reg, fgain_reg, inv_dt_reg;

    logic signed [DATA_W:0]   du_reg, du_next;
    q16_t                     prev_reg, prev_next;
    q16_t                     q_reg, q_next;
    logic                     elastic_reg, elastic_next;
    logic                     gneg_reg, gneg_next;
    logic                     sneg_reg, sneg_next;
    logic [DATA_W-1:0]        vel_reg, vel_next;
    logic [MUL_A_W-1:0]       a_reg, a_next;
    logic [MUL_B_W-1:0]       b_reg, b_next;
    logic                     ovalid_reg, ovalid_next;
    logic [DATA_W-1:0]        oforce_reg, oforce_next;
    logic [DATA_W-1:0]        ovel_reg, ovel_next;

    logic [PROD_W-1:0]        prod;
    logic [MAG_W-1:0]         pmag;
    logic signed [DATA_W:0]   du_in;
    logic [MUL_A_W-1:0]       du_in_mag, du_mag;
    logic [DATA_W-1:0]        q_abs;
    logic signed [DATA_W:0]   gdiff;
    logic [DATA_W-1:0]        hq_val;
    logic [DATA_W-1:0]        hq_mag;
    logic signed [MAG_W+1:0]  step_s, sum_s, plast_s;
    q16_t                     q_upd;
    logic [DATA_W-1:0]        q_upd_abs;
    logic                     accept;

    hfd_mul u_mul (
        .clk (clk),
        .a   (a_reg),
        .b   (b_reg),
        .p   (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yield_reg   <= '0;
            plastic_reg <= ONE_Q16_CFG;
            span_reg    <= ONE_Q16_CFG;
            fgain_reg   <= '0;
            inv_dt_reg  <= ONE_Q16_CFG;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_YIELD:   yield_reg   <= cfg_data;
                REG_PLASTIC: plastic_reg <= cfg_data;
                REG_SPAN:    span_reg    <= cfg_data;
                REG_FGAIN:   fgain_reg   <= cfg_data;
                REG_INV_DT:  inv_dt_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept    = in_ch.valid && in_ch.ready;
    assign pmag      = prod[PROD_W-1:FRAC_W];
    assign du_in     = {in_ch.displacement[DATA_W-1], in_ch.displacement}
                     - {prev_reg[DATA_W-1], prev_reg};
    assign du_in_mag = du_in[DATA_W] ? MUL_A_W'(-du_in) : MUL_A_W'(du_in);
    assign du_mag    = du_reg[DATA_W] ? MUL_A_W'(-du_reg) : MUL_A_W'(du_reg);
    assign q_abs     = q_reg[DATA_W-1] ? DATA_W'(-q_reg) : DATA_W'(q_reg);
    assign gdiff     = $signed({2'b00, plastic_reg}) - $signed({q_reg[DATA_W-1], q_reg});
    assign hq_val    = elastic_reg ? ONE_Q16 : sat_q16(gneg_reg, pmag);
    assign hq_mag    = hq_val[DATA_W-1] ? (32'd0 - hq_val) : hq_val;

    // hysteretic update and clamp to +/- plastic level
    assign step_s    = sneg_reg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    assign sum_s     = (MAG_W+2)'(q_reg) + step_s;
    assign plast_s   = $signed({{(MAG_W+2-CFG_W){1'b0}}, plastic_reg});
    always_comb
    begin
        if (sum_s > plast_s)
        begin
            q_upd = q16_t'(plast_s[DATA_W-1:0]);
        end
        else if (sum_s < -plast_s)
        begin
            q_upd = q16_t'(-plast_s[DATA_W-1:0]);
        end
        else
        begin
            q_upd = q16_t'(sum_s[DATA_W-1:0]);
        end
    end
    assign q_upd_abs = q_upd[DATA_W-1] ? DATA_W'(-q_upd) : DATA_W'(q_upd);

    always_comb
    begin
        state_next   = state_reg;
        du_next      = du_reg;
        prev_next    = prev_reg;
        q_next       = q_reg;
        elastic_next = elastic_reg;
        gneg_next    = gneg_reg;
        sneg_next    = sneg_reg;
        vel_next     = vel_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ovalid_next  = ovalid_reg && !out_ch.ready;
        oforce_next  = oforce_reg;
        ovel_next    = ovel_reg;

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    du_next    = du_in;
                    prev_next  = in_ch.displacement;
                    a_next     = du_in_mag;
                    b_next     = {1'b0, inv_dt_reg};
                    state_next = S_VEL;
                end
            end
            S_VEL:
            begin
                elastic_next = (q_abs <= {1'b0, yield_reg}) || (q_reg == '0)
                             || (du_reg == '0) || (q_reg[DATA_W-1] != du_reg[DATA_W]);
                gneg_next    = gdiff[DATA_W];
                a_next       = gdiff[DATA_W] ? MUL_A_W'(-gdiff) : MUL_A_W'(gdiff);
                b_next       = {1'b0, span_reg};
                state_next   = S_GAIN;
            end
            S_GAIN:
            begin
                vel_next   = sat_q16(du_reg[DATA_W], pmag);
                state_next = S_HQ;
            end
            S_HQ:
            begin
                a_next     = du_mag;
                b_next     = hq_mag;
                sneg_next  = hq_val[DATA_W-1] ^ du_reg[DATA_W];
                state_next = S_STEP;
            end
            S_STEP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                q_next     = q_upd;
                a_next     = MUL_A_W'(q_upd_abs);
                b_next     = {1'b0, fgain_reg};
                state_next = S_FORCE;
            end
            S_FORCE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    oforce_next = sat_q16(!q_reg[DATA_W-1], pmag);
                    ovel_next   = vel_reg;
                    state_next  = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            prev_reg   <= '0;
            q_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prev_reg   <= prev_next;
            q_reg      <= q_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        du_reg      <= du_next;
        elastic_reg <= elastic_next;
        gneg_reg    <= gneg_next;
        sneg_reg    <= sneg_next;
        vel_reg     <= vel_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        oforce_reg  <= oforce_next;
        ovel_reg    <= ovel_next;
    end

    assign in_ch.ready       = (state_reg == IDLE);
    assign out_ch.valid      = ovalid_reg;
    assign out_ch.drag_force = oforce_reg;
    assign out_ch.velocity   = ovel_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("input taken again right after accept");

    a_word_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg == S_OUT))
        else $error("output word loaded outside final step");

    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_VEL))
        else $error("sequencer did not start on accept");

endmodule

### tb/sv/tb_hysteretic_friction_damper_step.sv
`timescale 1ns / 100ps

module tb_hysteretic_friction_damper_step;
    import hfd_pkg::*;

    localparam int     CYCLE_LIMIT     = 200000;
    localparam int     RESET_CYCLES    = 11;
    localparam int     SETTLE_CYCLES   = 12;
    localparam int     LONG_HOLD       = 300;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     WORDS_PER_PHASE = 100;
    localparam int     REPORT_LIMIT    = 10;
    localparam longint WORD_MAX        = 64'sd2147483647;
    localparam longint WORD_MIN        = -WORD_MAX - 1;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    typedef struct packed {
        q16_t drag_force;
        q16_t velocity;
    } damper_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    hfd_in_if  in_ch();
    hfd_out_if out_ch();

    hysteretic_friction_damper_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register mirror, reset values
    logic [CFG_W-1:0] yield_cfg   = '0;
    logic [CFG_W-1:0] plastic_cfg = ONE_Q16_CFG;
    logic [CFG_W-1:0] span_cfg    = ONE_Q16_CFG;
    logic [CFG_W-1:0] gain_cfg    = '0;
    logic [CFG_W-1:0] inv_dt_cfg  = ONE_Q16_CFG;

    // damper state
    q16_t hyst_state = '0;
    q16_t last_disp  = '0;

    q16_t           pending_words[$];
    damper_result_t due_outputs[$];

    int  words_sent          = 0;
    int  words_checked       = 0;
    int  mismatches          = 0;
    int  yielding_steps      = 0;
    int  clamp_hits          = 0;
    int  saturated_words     = 0;
    int  settings_loaded     = 0;
    int  long_stall_requests = 0;
    int  long_seen;
    int  hold_left;
    int  stall_left;
    int  send_gap;
    int  cycles              = 0;
    bit  quiet_tail          = 1'b0;

    longint walk_pos        = 0;
    longint walk_dir        = 1;
    int     walk_left       = 0;
    longint walk_stride_max = 16384;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // sign-magnitude Q16.16 product, truncated toward zero
    function automatic longint fixed_mul(input longint a, input longint b);
        bit              neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >> 16;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    task automatic predict_damper_step(input q16_t disp);
        longint         q;
        longint         du;
        longint         hq;
        longint         vel;
        longint         frc;
        longint         plast;
        longint         yl;
        bit             elastic;
        damper_result_t r;
        q = longint'(hyst_state);
        du = longint'(disp) - longint'(last_disp);
        plast = longint'(plastic_cfg);
        yl = longint'(yield_cfg);
        vel = fixed_mul(du, longint'(inv_dt_cfg));
        elastic = (q <= yl && -q <= yl) || q == 0 || du == 0 || ((q < 0) != (du < 0));
        if (elastic)
            hq = longint'(ONE_Q16);
        else
        begin
            hq = sat_word(fixed_mul(plast - q, longint'(span_cfg)));
            yielding_steps++;
        end
        q = q + fixed_mul(hq, du);
        if (q > plast)
        begin
            q = plast;
            clamp_hits++;
        end
        else if (q < -plast)
        begin
            q = -plast;
            clamp_hits++;
        end
        hyst_state = q16_t'(q);
        last_disp = disp;
        frc = -fixed_mul(q, longint'(gain_cfg));
        if (sat_word(frc) != frc || sat_word(vel) != vel)
            saturated_words++;
        r.drag_force = q16_t'(sat_word(frc));
        r.velocity = q16_t'(sat_word(vel));
        due_outputs.push_back(r);
    endtask

    function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] v);
        case (idx)
            REG_YIELD:   yield_cfg = v;
            REG_PLASTIC: plastic_cfg = v;
            REG_SPAN:    span_cfg = v;
            REG_FGAIN:   gain_cfg = v;
            REG_INV_DT:  inv_dt_cfg = v;
            default:     ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        mirror_reg(idx, v);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] yl, input logic [CFG_W-1:0] pl,
                                 input logic [CFG_W-1:0] sp, input logic [CFG_W-1:0] fg,
                                 input logic [CFG_W-1:0] dt, input bit stray);
        longint reach;
        write_reg(REG_YIELD, yl);
        write_reg(REG_PLASTIC, pl);
        write_reg(REG_SPAN, sp);
        write_reg(REG_FGAIN, fg);
        write_reg(REG_INV_DT, dt);
        // unused indexes must be ignored
        if (stray)
        begin
            for (int i = REG_INV_DT + 1; i < (1 << CFG_IDX_W); i++)
                write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
        reach = (pl == 0) ? 65536 : longint'(pl);
        walk_stride_max = reach / 4 + 1;
        if (walk_stride_max > (1 << 30))
            walk_stride_max = 1 << 30;
    endtask

    task automatic pick_random_settings(input bit stray);
        logic [CFG_W-1:0] yl;
        logic [CFG_W-1:0] pl;
        logic [CFG_W-1:0] sp;
        logic [CFG_W-1:0] fg;
        logic [CFG_W-1:0] dt;
        longint           span_gap;
        longint           recip;
        case ($urandom_range(0, 7))
            0:       pl = '0;
            1:       pl = CFG_MAX;
            2:       pl = CFG_W'($urandom);
            default: pl = CFG_W'($urandom_range(4096, 1 << 22));
        endcase
        case ($urandom_range(0, 7))
            0:       yl = '0;
            1:       yl = CFG_MAX;
            2:       yl = CFG_W'($urandom);
            default: yl = CFG_W'($urandom_range(0, pl));
        endcase
        span_gap = longint'(pl) - longint'(yl);
        if (span_gap <= 0 || $urandom_range(0, 7) == 0)
            sp = CFG_W'($urandom);
        else
        begin
            recip = (longint'(1) << 32) / span_gap;
            sp = (recip > WORD_MAX) ? CFG_MAX : CFG_W'(recip);
        end
        case ($urandom_range(0, 7))
            0:       fg = '0;
            1:       fg = CFG_MAX;
            2:       fg = CFG_W'($urandom);
            default: fg = CFG_W'($urandom_range(0, 1 << 22));
        endcase
        case ($urandom_range(0, 7))
            0:       dt = '0;
            1:       dt = CFG_MAX;
            2:       dt = CFG_W'($urandom);
            default: dt = CFG_W'($urandom_range(1 << 10, 1 << 24));
        endcase
        load_settings(yl, pl, sp, fg, dt, stray);
    endtask

    // mostly smooth back-and-forth motion, some jumps and full-range noise
    function automatic q16_t next_random_displacement();
        int     pick;
        longint stride;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            walk_pos = longint'(q16_t'($urandom));
        else if (pick < 12)
        begin
            case ($urandom_range(0, 2))
                0:       walk_pos = WORD_MAX;
                1:       walk_pos = WORD_MIN;
                default: walk_pos = 0;
            endcase
        end
        else if (pick >= 14)
        begin
            if (walk_left == 0)
            begin
                walk_dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
                walk_left = $urandom_range(2, 30);
            end
            walk_left--;
            stride = longint'($urandom_range(0, 32'(walk_stride_max)));
            walk_pos = sat_word(walk_pos + walk_dir * stride);
        end
        return q16_t'(walk_pos);
    endfunction

    task automatic queue_random_words(input int n);
        repeat (n) pending_words.push_back(next_random_displacement());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || due_outputs.size() != 0 || in_ch.valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_field(input string field, input q16_t want, input q16_t got);
        if (mismatches < REPORT_LIMIT)
            $display("word %0d %s: expected %h, got %h", words_checked, field, want, got);
        mismatches++;
    endtask

    task automatic check_output(input q16_t got_force, input q16_t got_vel);
        damper_result_t want;
        words_checked++;
        if (due_outputs.size() == 0)
        begin
            if (mismatches < REPORT_LIMIT)
                $display("word %0d arrived unrequested: drag_force %h velocity %h",
                         words_checked, got_force, got_vel);
            mismatches++;
        end
        else
        begin
            want = due_outputs.pop_front();
            if (got_force !== want.drag_force)
                report_field("drag_force", want.drag_force, got_force);
            if (got_vel !== want.velocity)
                report_field("velocity", want.velocity, got_vel);
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.displacement <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_damper_step(in_ch.displacement);
                words_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                    in_ch.valid <= 1'b0;
                else if (!quiet_tail && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(0, 6);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.displacement <= pending_words.pop_front();
                end
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
            stall_left <= 0;
            long_seen <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_output(out_ch.drag_force, out_ch.velocity);
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (long_seen != long_stall_requests)
            begin
                long_seen <= long_stall_requests;
                hold_left <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_hysteretic_friction_damper_step: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero force gain, unit span and time step
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'h0000_8000);
        pending_words.push_back(32'h0001_0000);
        wait_drained();

        // yield 0.5, plastic 1.0, span 2.0, gain 10, 1/dt 100
        load_settings(31'h0000_8000, 31'h0001_0000, 31'h0002_0000, 31'h000A_0000,
                      31'h0064_0000, 1'b0);
        pending_words.push_back(32'h0001_8000);
        pending_words.push_back(32'h0003_0000);
        pending_words.push_back(32'h0002_0000);
        pending_words.push_back(32'h0002_0000);
        pending_words.push_back(-32'sh0003_0000);
        pending_words.push_back(32'h7FFF_FFFF);
        pending_words.push_back(32'h8000_0000);
        pending_words.push_back(32'h8000_0000);
        pending_words.push_back(32'h7FFF_FFFF);
        wait_drained();

        // everything at full scale
        load_settings(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, 1'b1);
        pending_words.push_back(32'h7FFF_FFFF);
        pending_words.push_back(32'h8000_0000);
        pending_words.push_back(32'h7FFF_FFFF);
        pending_words.push_back(32'h7FFF_FFFE);
        pending_words.push_back(32'h7FFF_FFFF);
        pending_words.push_back(32'h7FFF_0000);
        wait_drained();

        // plastic level dropped far below the held q: negative, saturated gain
        load_settings(31'h0000_0000, 31'h0000_4000, 31'h0004_0000, 31'h0001_0000,
                      31'h0001_0000, 1'b1);
        pending_words.push_back(32'h7FFF_FFFF);
        pending_words.push_back(32'h7FFF_8000);
        wait_drained();

        load_settings('0, '0, '0, '0, '0, 1'b0);
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'h1234_5678);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            pick_random_settings(ph % 3 == 0);
            if (ph == 1)
                long_stall_requests++;
            queue_random_words(WORDS_PER_PHASE / 2);
            if (ph % 2 == 1)
                wait_drained();
            queue_random_words(WORDS_PER_PHASE - WORDS_PER_PHASE / 2);
            wait_drained();
        end

        $display("summary: %0d displacement words checked under %0d register settings",
                 words_checked, settings_loaded);
        $display("summary: %0d yielding steps, %0d clamps at plastic level, %0d saturated words",
                 yielding_steps, clamp_hits, saturated_words);
        if (mismatches == 0 && due_outputs.size() == 0)
            $display("tb_hysteretic_friction_damper_step: done, clean");
        else
            $display("tb_hysteretic_friction_damper_step: done, errors");
        $finish;
    end

endmodule
